FILE: rtl/core/vmsrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmsrd_pkg
// Shared types and constants for the record stream deframer.
// ----------------------------------------------------------------------------
package vmsrd_pkg;

    // request actions
    localparam logic [1:0] ACT_DATA      = 2'd0;
    localparam logic [1:0] ACT_BUF_START = 2'd1;
    localparam logic [1:0] ACT_NEW_FILE  = 2'd2;

    // record format codes
    localparam logic [2:0] FMT_FIXED     = 3'd0;
    localparam logic [2:0] FMT_VARIABLE  = 3'd1;
    localparam logic [2:0] FMT_VFC       = 3'd2;
    localparam logic [2:0] FMT_STREAM    = 3'd3;
    localparam logic [2:0] FMT_STREAM_CR = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_RECORD_FORMAT = 2'd0;
    localparam logic [1:0] REG_FILE_SIZE     = 2'd1;
    localparam logic [1:0] REG_VFC_HDR_SIZE  = 2'd2;
    localparam logic [1:0] REG_BINARY_MODE   = 2'd3;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [7:0] VFC_HDR_RESET = 8'd2;

    localparam int OUT_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_LEN_LO = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_HDR    = 3'd2,
        PH_DATA   = 3'd3,
        PH_PAD    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [31:0] bytes_consumed;
        logic [15:0] record_remaining;
        phase_t      parse_phase;
        logic [7:0]  length_low_byte;
        logic [7:0]  header_skip_left;
        logic        buffer_offset_odd;
    } state_t;

    typedef struct packed {
        logic [2:0]  record_format;
        logic [31:0] file_size;
        logic [7:0]  vfc_header_size;
        logic        binary_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       format_error;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/vms_record_stream_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vms_record_stream_deframer
// Converts record-structured file bytes into a plain output byte stream.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid/in_ready, action,       request into block
//            data_byte
//  out       out_valid/out_ready, out_byte,   result out of block
//            format_error, last_of_run
//  cfg       cfg_wr_en, cfg_index, cfg_data   register write, no handshake
//
//  One request per cycle while in_ready is high; its parse work completes in
//  the accept cycle and the results are registered into a result queue of
//  OUT_DEPTH entries. A request that passes a byte and adds a newline gives
//  two results; the queue's one read port sets the output rate.
//  in_ready drops while the queue has fewer than two free entries.
//  Reset clears parse state and queue; vfc_header_size resets to 2.
// ----------------------------------------------------------------------------
module vms_record_stream_deframer #(
    parameter int OUT_DEPTH = vmsrd_pkg::OUT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             format_error,
    output logic             last_of_run,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    vmsrd_pkg::cfg_t      cfg_reg;
    vmsrd_pkg::state_t    state_reg, state_next;
    vmsrd_pkg::step_res_t step_res;
    vmsrd_pkg::result_t   head;
    logic                 in_accept;
    logic                 space2;
    logic [$clog2(OUT_DEPTH+1)-1:0] level;

    assign in_ready  = space2;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.record_format   <= vmsrd_pkg::FMT_FIXED;
            cfg_reg.file_size       <= 32'd0;
            cfg_reg.vfc_header_size <= vmsrd_pkg::VFC_HDR_RESET;
            cfg_reg.binary_mode     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vmsrd_pkg::REG_RECORD_FORMAT: cfg_reg.record_format   <= cfg_data[2:0];
                vmsrd_pkg::REG_FILE_SIZE:     cfg_reg.file_size       <= cfg_data;
                vmsrd_pkg::REG_VFC_HDR_SIZE:  cfg_reg.vfc_header_size <= cfg_data[7:0];
                vmsrd_pkg::REG_BINARY_MODE:   cfg_reg.binary_mode     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    vmsrd_step u_step (
        .action    (action),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .st        (state_reg),
        .st_next   (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.bytes_consumed    <= 32'd0;
            state_reg.record_remaining  <= 16'd0;
            state_reg.parse_phase       <= vmsrd_pkg::PH_LEN_LO;
            state_reg.length_low_byte   <= 8'd0;
            state_reg.header_skip_left  <= 8'd0;
            state_reg.buffer_offset_odd <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    vmsrd_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (step_res),
        .push_en (in_accept),
        .space2  (space2),
        .valid   (out_valid),
        .pop     (out_ready),
        .head    (head),
        .level   (level)
    );

    assign out_byte     = head.out_byte;
    assign format_error = head.format_error;
    assign last_of_run  = head.last_of_run;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($clog2(OUT_DEPTH+1))'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && format_error |-> out_byte == 8'd0 && last_of_run)
        else $error("error result malformed");

    a_new_file_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && action == vmsrd_pkg::ACT_NEW_FILE |=> state_reg.bytes_consumed == 32'd0)
        else $error("byte count not cleared on new file");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && action != vmsrd_pkg::ACT_NEW_FILE
        |=> state_reg.bytes_consumed >= $past(state_reg.bytes_consumed))
        else $error("byte count went backwards");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/vmsrd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmsrd_step
// Per-byte parse logic: next state and up to two result items.
// ----------------------------------------------------------------------------
module vmsrd_step (
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         data_byte,
    input  wire vmsrd_pkg::cfg_t    cfg,
    input  wire vmsrd_pkg::state_t  st,
    output vmsrd_pkg::state_t       st_next,
    output vmsrd_pkg::step_res_t    res
);

    logic        cur_odd;
    logic        next_odd;
    logic        pb_en;
    logic [7:0]  pb_val;
    logic        pb_err;
    logic        nl_en;
    logic [15:0] len;
    logic [15:0] hdr_ext;
    logic [15:0] rem_new;
    logic [7:0]  hdr_new;
    logic [7:0]  hdr_dec;
    logic [15:0] rem_dec;

    assign len     = {data_byte, st.length_low_byte};
    assign hdr_ext = {8'd0, cfg.vfc_header_size};
    assign hdr_dec = (st.header_skip_left != 8'd0) ? st.header_skip_left - 8'd1 : 8'd0;
    assign rem_dec = (st.record_remaining != 16'd0) ? st.record_remaining - 16'd1 : 16'd0;

    always_comb
    begin
        st_next  = st;
        pb_en    = 1'b0;
        pb_val   = data_byte;
        pb_err   = 1'b0;
        nl_en    = 1'b0;
        rem_new  = 16'd0;
        hdr_new  = 8'd0;
        cur_odd  = (action == vmsrd_pkg::ACT_BUF_START) ? 1'b0 : st.buffer_offset_odd;
        next_odd = ~cur_odd;

        case (action)
            vmsrd_pkg::ACT_NEW_FILE:
            begin
                st_next.bytes_consumed   = 32'd0;
                st_next.record_remaining = 16'd0;
                st_next.parse_phase      = vmsrd_pkg::PH_LEN_LO;
                st_next.length_low_byte  = 8'd0;
                st_next.header_skip_left = 8'd0;
            end
            vmsrd_pkg::ACT_DATA, vmsrd_pkg::ACT_BUF_START:
            begin
                st_next.buffer_offset_odd = next_odd;
                if (st.bytes_consumed < cfg.file_size)
                begin
                    st_next.bytes_consumed = st.bytes_consumed + 32'd1;
                    case (cfg.record_format)
                        vmsrd_pkg::FMT_FIXED, vmsrd_pkg::FMT_STREAM:
                        begin
                            pb_en = 1'b1;
                        end
                        vmsrd_pkg::FMT_STREAM_CR:
                        begin
                            pb_en = 1'b1;
                            if (data_byte == vmsrd_pkg::CHAR_CR && !cfg.binary_mode)
                                pb_val = vmsrd_pkg::CHAR_LF;
                        end
                        vmsrd_pkg::FMT_VARIABLE, vmsrd_pkg::FMT_VFC:
                        begin
                            case (st.parse_phase)
                                vmsrd_pkg::PH_LEN_HI:
                                begin
                                    pb_en = cfg.binary_mode;
                                    if (cfg.record_format == vmsrd_pkg::FMT_VFC)
                                    begin
                                        hdr_new = cfg.vfc_header_size;
                                        rem_new = (len > hdr_ext) ? len - hdr_ext : 16'd0;
                                    end
                                    else
                                    begin
                                        hdr_new = 8'd0;
                                        rem_new = len;
                                    end
                                    st_next.header_skip_left = hdr_new;
                                    st_next.record_remaining = rem_new;
                                    if (hdr_new != 8'd0)
                                        st_next.parse_phase = vmsrd_pkg::PH_HDR;
                                    else if (rem_new != 16'd0)
                                        st_next.parse_phase = vmsrd_pkg::PH_DATA;
                                    else
                                    begin
                                        nl_en = ~cfg.binary_mode;
                                        st_next.parse_phase = next_odd ? vmsrd_pkg::PH_PAD
                                                                       : vmsrd_pkg::PH_LEN_LO;
                                    end
                                end
                                vmsrd_pkg::PH_HDR:
                                begin
                                    pb_en = cfg.binary_mode;
                                    st_next.header_skip_left = hdr_dec;
                                    if (hdr_dec == 8'd0)
                                    begin
                                        if (st.record_remaining != 16'd0)
                                            st_next.parse_phase = vmsrd_pkg::PH_DATA;
                                        else
                                        begin
                                            nl_en = ~cfg.binary_mode;
                                            st_next.parse_phase = next_odd ? vmsrd_pkg::PH_PAD
                                                                           : vmsrd_pkg::PH_LEN_LO;
                                        end
                                    end
                                end
                                vmsrd_pkg::PH_DATA:
                                begin
                                    pb_en = 1'b1;
                                    st_next.record_remaining = rem_dec;
                                    if (rem_dec == 16'd0)
                                    begin
                                        nl_en = ~cfg.binary_mode;
                                        st_next.parse_phase = next_odd ? vmsrd_pkg::PH_PAD
                                                                       : vmsrd_pkg::PH_LEN_LO;
                                    end
                                end
                                vmsrd_pkg::PH_PAD:
                                begin
                                    pb_en = cfg.binary_mode;
                                    st_next.parse_phase = vmsrd_pkg::PH_LEN_LO;
                                end
                                default:
                                begin
                                    // PH_LEN_LO and unknown phase codes take the length low byte
                                    pb_en = cfg.binary_mode;
                                    st_next.length_low_byte = data_byte;
                                    st_next.parse_phase     = vmsrd_pkg::PH_LEN_HI;
                                end
                            endcase
                        end
                        default:
                        begin
                            pb_en  = 1'b1;
                            pb_val = 8'd0;
                            pb_err = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                // unused action: hold everything
            end
        endcase
    end

    // byte first, newline second
    always_comb
    begin
        res.count = {1'b0, pb_en} + {1'b0, nl_en};
        res.res0.out_byte     = pb_en ? pb_val : vmsrd_pkg::CHAR_LF;
        res.res0.format_error = pb_en & pb_err;
        res.res0.last_of_run  = ~(pb_en & nl_en);
        res.res1.out_byte     = vmsrd_pkg::CHAR_LF;
        res.res1.format_error = 1'b0;
        res.res1.last_of_run  = 1'b1;
    end

endmodule
`default_nettype wire

FILE: rtl/core/vmsrd_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vmsrd_outq
// Small result queue: takes up to two results a cycle, gives one a cycle while pop is high.
// ----------------------------------------------------------------------------
module vmsrd_outq #(
    parameter int DEPTH = vmsrd_pkg::OUT_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vmsrd_pkg::step_res_t push,
    input  wire logic                push_en,
    output logic                     space2,
    output logic                     valid,
    input  wire logic                pop,
    output vmsrd_pkg::result_t       head,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    vmsrd_pkg::result_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_p1;
    logic [PW-1:0] wr_ptr_p2;
    logic [1:0]    n_push;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign n_push    = push_en ? push.count : 2'd0;
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);
    assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);

    assign valid  = (count_reg != '0);
    assign head   = mem[rd_ptr_reg];
    assign space2 = (count_reg <= CW'(DEPTH - 2));
    assign level  = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (n_push)
            2'd1:    wr_ptr_next = wr_ptr_p1;
            2'd2:    wr_ptr_next = wr_ptr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = (pop && valid) ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(n_push) - CW'(pop && valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_ptr_reg] <= push.res0;
        if (n_push == 2'd2)
            mem[wr_ptr_p1] <= push.res1;
    end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record stream deframer.
// A directed table of requests and register writes goes first, then phases
// of random requests under different record formats, file sizes, VFC header
// sizes and text/binary modes. Every accepted request is run through a local
// model of the deframer, and each byte leaving the block is checked against
// the oldest outstanding prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int N_PHASES    = 12;
    localparam int PHASE_BYTES = 70;
    localparam int PHASE_TRIES = 160;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] FMT_RSVD5  = 3'd5;
    localparam logic [2:0] FMT_RSVD6  = 3'd6;
    localparam logic [2:0] FMT_RSVD7  = 3'd7;
    localparam bit         ROW_CFG    = 1'b1;
    localparam bit         ROW_REQ    = 1'b0;

    typedef struct packed {
        bit          cfg_row;
        logic [1:0]  sel;
        logic [31:0] value;
        bit          typed;
        logic [1:0]  n_exp;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        bit          err;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        format_error;
    logic        last_of_run;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // local copy of the registers
    logic [2:0]  cfg_fmt;
    logic [31:0] cfg_fsize;
    logic [7:0]  cfg_hdr;
    logic        cfg_raw;

    // local copy of the parse state
    logic [31:0]       st_count;
    logic [15:0]       st_left;
    vmsrd_pkg::phase_t st_phase;
    logic [7:0]        st_len_lo;
    logic [7:0]        st_hdr_left;
    logic              st_odd;
    bit                byte_taken;

    vmsrd_pkg::result_t pending_bytes[$];
    dir_row_t           dir_rows[$];

    int   error_count   = 0;
    int   req_count     = 0;
    int   checked_count = 0;
    int   write_count   = 0;
    int   hold_count    = 0;
    int   rx_stall_pct  = 30;
    int   burst_left    = 0;
    bit   sender_idle   = 1'b1;
    bit   hold_req      = 1'b0;
    logic [7:0] planned_hi = 8'h00;

    vms_record_stream_deframer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .format_error (format_error),
        .last_of_run  (last_of_run),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic void put_byte(input logic [7:0] v, input logic err);
        vmsrd_pkg::result_t r;
        r.out_byte     = v;
        r.format_error = err;
        r.last_of_run  = 1'b0;
        pending_bytes.push_back(r);
    endfunction

    function automatic void mark_last(input int n);
        if (n > 0)
            pending_bytes[pending_bytes.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void close_record(input logic nxt);
        if (!cfg_raw)
            put_byte(vmsrd_pkg::CHAR_LF, 1'b0);
        st_phase = nxt ? vmsrd_pkg::PH_PAD : vmsrd_pkg::PH_LEN_LO;
    endfunction

    // Predict the bytes one request gives and advance the local parse state.
    function automatic void deframe_step(input logic [1:0] act, input logic [7:0] b);
        logic        nxt;
        logic [15:0] len;
        byte_taken = 1'b0;
        if (act == ACT_UNUSED)
            return;
        if (act == vmsrd_pkg::ACT_NEW_FILE)
        begin
            st_count    = '0;
            st_left     = '0;
            st_phase    = vmsrd_pkg::PH_LEN_LO;
            st_len_lo   = '0;
            st_hdr_left = '0;
            return;
        end
        nxt    = (act == vmsrd_pkg::ACT_BUF_START) ? 1'b1 : ~st_odd;
        st_odd = nxt;
        if (st_count >= cfg_fsize)
            return;
        st_count   = st_count + 32'd1;
        byte_taken = 1'b1;
        case (cfg_fmt)
            vmsrd_pkg::FMT_FIXED, vmsrd_pkg::FMT_STREAM:
                put_byte(b, 1'b0);
            vmsrd_pkg::FMT_STREAM_CR:
                put_byte((b == vmsrd_pkg::CHAR_CR && !cfg_raw) ? vmsrd_pkg::CHAR_LF : b, 1'b0);
            vmsrd_pkg::FMT_VARIABLE, vmsrd_pkg::FMT_VFC:
            begin
                case (st_phase)
                    vmsrd_pkg::PH_LEN_HI:
                    begin
                        if (cfg_raw)
                            put_byte(b, 1'b0);
                        len = {b, st_len_lo};
                        if (cfg_fmt == vmsrd_pkg::FMT_VFC)
                        begin
                            st_hdr_left = cfg_hdr;
                            st_left = (len > 16'(cfg_hdr)) ? len - 16'(cfg_hdr) : 16'd0;
                        end
                        else
                        begin
                            st_hdr_left = '0;
                            st_left     = len;
                        end
                        if (st_hdr_left != 0)
                            st_phase = vmsrd_pkg::PH_HDR;
                        else if (st_left != 0)
                            st_phase = vmsrd_pkg::PH_DATA;
                        else
                            close_record(nxt);
                    end
                    vmsrd_pkg::PH_HDR:
                    begin
                        if (cfg_raw)
                            put_byte(b, 1'b0);
                        if (st_hdr_left != 0)
                            st_hdr_left = st_hdr_left - 8'd1;
                        if (st_hdr_left == 0)
                        begin
                            if (st_left != 0)
                                st_phase = vmsrd_pkg::PH_DATA;
                            else
                                close_record(nxt);
                        end
                    end
                    vmsrd_pkg::PH_DATA:
                    begin
                        put_byte(b, 1'b0);
                        if (st_left != 0)
                            st_left = st_left - 16'd1;
                        if (st_left == 0)
                            close_record(nxt);
                    end
                    vmsrd_pkg::PH_PAD:
                    begin
                        if (cfg_raw)
                            put_byte(b, 1'b0);
                        st_phase = vmsrd_pkg::PH_LEN_LO;
                    end
                    default:
                    begin
                        if (cfg_raw)
                            put_byte(b, 1'b0);
                        st_len_lo = b;
                        st_phase  = vmsrd_pkg::PH_LEN_HI;
                    end
                endcase
            end
            default:
                put_byte(8'h00, 1'b1);
        endcase
    endfunction

    function automatic void add_row(input bit c, input logic [1:0] s, input logic [31:0] v,
                                    input bit t = 1'b0, input logic [1:0] n = 2'd0,
                                    input logic [7:0] b0 = 8'h00, input logic [7:0] b1 = 8'h00,
                                    input bit e = 1'b0);
        dir_row_t r;
        r.cfg_row = c;
        r.sel     = s;
        r.value   = v;
        r.typed   = t;
        r.n_exp   = n;
        r.byte0   = b0;
        r.byte1   = b1;
        r.err     = e;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return vmsrd_pkg::ACT_NEW_FILE;
        if (r < 4)
            return ACT_UNUSED;
        if (r < 10)
            return vmsrd_pkg::ACT_BUF_START;
        return vmsrd_pkg::ACT_DATA;
    endfunction

    // Mostly well-formed records with short lengths; the rest is noise.
    function automatic logic [7:0] pick_byte();
        int  len;
        bit  recs;
        recs = (cfg_fmt == vmsrd_pkg::FMT_VARIABLE || cfg_fmt == vmsrd_pkg::FMT_VFC);
        if ($urandom_range(99) < 10)
            return 8'($urandom);
        if (cfg_fmt == vmsrd_pkg::FMT_STREAM_CR && $urandom_range(3) == 0)
            return vmsrd_pkg::CHAR_CR;
        if (recs && st_phase == vmsrd_pkg::PH_LEN_LO)
        begin
            len = $urandom_range(0, 9);
            if (cfg_fmt == vmsrd_pkg::FMT_VFC)
                len = len + int'(cfg_hdr) - 2;
            if (len < 0)
                len = 0;
            planned_hi = 8'(len >> 8);
            return 8'(len);
        end
        if (recs && st_phase == vmsrd_pkg::PH_LEN_HI)
            return planned_hi;
        return 8'($urandom);
    endfunction

    function automatic int next_gap();
        if (!sender_idle)
            return 0;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 12);
        return $urandom_range(1, 6);
    endfunction

    task automatic push_req(input logic [1:0] act, input logic [7:0] b, output int n_new);
        int base;
        action    <= act;
        data_byte <= b;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        base = pending_bytes.size();
        deframe_step(act, b);
        n_new = pending_bytes.size() - base;
        mark_last(n_new);
        req_count++;
    endtask

    task automatic idle_gap();
        int g;
        g = next_gap();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Hold requests back until every predicted byte has left the block.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            vmsrd_pkg::REG_RECORD_FORMAT: cfg_fmt   = val[2:0];
            vmsrd_pkg::REG_FILE_SIZE:     cfg_fsize = val;
            vmsrd_pkg::REG_VFC_HDR_SIZE:  cfg_hdr   = val[7:0];
            default:                      cfg_raw   = val[0];
        endcase
        write_count++;
        @(posedge clk);
    endtask

    task automatic setup_phase(input int p);
        logic [2:0]  f;
        logic [31:0] sz;
        logic [7:0]  h;
        logic        bin;
        sz           = 32'hFFFF_FFFF;
        h            = vmsrd_pkg::VFC_HDR_RESET;
        bin          = 1'b0;
        sender_idle  = 1'b1;
        rx_stall_pct = $urandom_range(10, 60);
        case (p)
            0:
            begin
                f           = vmsrd_pkg::FMT_VARIABLE;
                sender_idle = 1'b0;
                hold_req    = 1'b1;
            end
            1:
            begin
                f            = vmsrd_pkg::FMT_VFC;
                h            = 8'd0;
                sender_idle  = 1'b0;
                rx_stall_pct = 0;
            end
            2:
            begin
                f   = vmsrd_pkg::FMT_VFC;
                h   = 8'd255;
                bin = 1'b1;
            end
            3:
            begin
                f  = vmsrd_pkg::FMT_VFC;
                h  = 8'd3;
                sz = $urandom_range(150, 400);
            end
            4:  f = vmsrd_pkg::FMT_STREAM_CR;
            5:
            begin
                f           = vmsrd_pkg::FMT_STREAM_CR;
                bin         = 1'b1;
                sender_idle = 1'b0;
                hold_req    = 1'b1;
            end
            6:
            begin
                f  = vmsrd_pkg::FMT_FIXED;
                sz = 32'd40;
            end
            7:
            begin
                f            = vmsrd_pkg::FMT_STREAM;
                sz           = 32'd0;
                sender_idle  = 1'b0;
                rx_stall_pct = 0;
            end
            8:  f = FMT_RSVD6;
            9:
            begin
                f            = vmsrd_pkg::FMT_VARIABLE;
                bin          = 1'b1;
                h            = 8'd0;
                rx_stall_pct = 70;
            end
            10:
            begin
                f   = 3'($urandom_range(0, 7));
                h   = 8'($urandom_range(0, 8));
                bin = 1'($urandom_range(0, 1));
                if ($urandom_range(1))
                    sz = $urandom;
            end
            default:
            begin
                f = vmsrd_pkg::FMT_VFC;
                h = 8'd1;
            end
        endcase
        write_reg(vmsrd_pkg::REG_RECORD_FORMAT, 32'(f));
        write_reg(vmsrd_pkg::REG_FILE_SIZE, sz);
        write_reg(vmsrd_pkg::REG_VFC_HDR_SIZE, 32'(h));
        write_reg(vmsrd_pkg::REG_BINARY_MODE, 32'(bin));
    endtask

    // receiver: random stalls, plus a long hold-off on demand
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                hold_count++;
            end
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        vmsrd_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected result byte=%02h err=%0b last=%0b",
                         $realtime, out_byte, format_error, last_of_run);
                error_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                checked_count++;
                if (out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $realtime, want.out_byte, out_byte);
                    error_count++;
                end
                if (format_error !== want.format_error)
                begin
                    $display("%0t: format_error expected %0b, got %0b",
                             $realtime, want.format_error, format_error);
                    error_count++;
                end
                if (last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %0b, got %0b",
                             $realtime, want.last_of_run, last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int n;
        int taken;
        int tries;
        logic [1:0] a;
        logic [7:0] b;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = vmsrd_pkg::ACT_DATA;
        data_byte = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_index = vmsrd_pkg::REG_RECORD_FORMAT;
        cfg_data  = 32'd0;

        cfg_fmt     = vmsrd_pkg::FMT_FIXED;
        cfg_fsize   = 32'd0;
        cfg_hdr     = vmsrd_pkg::VFC_HDR_RESET;
        cfg_raw     = 1'b0;
        st_count    = '0;
        st_left     = '0;
        st_phase    = vmsrd_pkg::PH_LEN_LO;
        st_len_lo   = '0;
        st_hdr_left = '0;
        st_odd      = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // file size is zero out of reset, so the first byte is dropped
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'hFF, 1'b1, 2'd0);
        add_row(ROW_CFG, vmsrd_pkg::REG_FILE_SIZE, 32'hFFFF_FFFF);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h00, 1'b1, 2'd1, 8'h00);
        add_row(ROW_REQ, vmsrd_pkg::ACT_BUF_START, 32'hFF, 1'b1, 2'd1, 8'hFF);
        add_row(ROW_CFG, vmsrd_pkg::REG_RECORD_FORMAT, 32'(vmsrd_pkg::FMT_STREAM_CR));
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h0D, 1'b1, 2'd1, 8'h0A);
        add_row(ROW_CFG, vmsrd_pkg::REG_BINARY_MODE, 32'd1);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h0D, 1'b1, 2'd1, 8'h0D);
        add_row(ROW_CFG, vmsrd_pkg::REG_BINARY_MODE, 32'd0);
        add_row(ROW_CFG, vmsrd_pkg::REG_RECORD_FORMAT, 32'(FMT_RSVD7));
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h5A, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1);
        add_row(ROW_CFG, vmsrd_pkg::REG_RECORD_FORMAT, 32'(FMT_RSVD5));
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'hA5, 1'b1, 2'd1, 8'h00, 8'h00, 1'b1);
        add_row(ROW_REQ, ACT_UNUSED, 32'h33, 1'b1, 2'd0);
        add_row(ROW_CFG, vmsrd_pkg::REG_RECORD_FORMAT, 32'(vmsrd_pkg::FMT_VARIABLE));
        add_row(ROW_REQ, vmsrd_pkg::ACT_NEW_FILE, 32'h00, 1'b1, 2'd0);
        add_row(ROW_REQ, vmsrd_pkg::ACT_BUF_START, 32'h02);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h00);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h41, 1'b1, 2'd1, 8'h41);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h42, 1'b1, 2'd2, 8'h42, 8'h0A);
        // one-byte record ending on an odd offset, then its pad byte
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h01);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h00);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h43, 1'b1, 2'd2, 8'h43, 8'h0A);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'hEE, 1'b1, 2'd0);
        // length split across two buffers
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h01);
        add_row(ROW_REQ, vmsrd_pkg::ACT_BUF_START, 32'h00);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h44, 1'b1, 2'd2, 8'h44, 8'h0A);
        // empty record: newline straight after the length
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h00);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h00, 1'b1, 2'd1, 8'h0A);
        // VFC length below the reset header size: skip header, empty record
        add_row(ROW_CFG, vmsrd_pkg::REG_RECORD_FORMAT, 32'(vmsrd_pkg::FMT_VFC));
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h01);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h00);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h77, 1'b1, 2'd0);
        add_row(ROW_REQ, vmsrd_pkg::ACT_DATA, 32'h88, 1'b1, 2'd1, 8'h0A);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_row)
            begin
                wait_quiet();
                write_reg(dir_rows[i].sel, dir_rows[i].value);
            end
            else
            begin
                push_req(dir_rows[i].sel, dir_rows[i].value[7:0], n);
                if (dir_rows[i].typed)
                begin
                    // swap the prediction for the bytes given in the row
                    repeat (n) void'(pending_bytes.pop_back());
                    if (dir_rows[i].n_exp != 0)
                        put_byte(dir_rows[i].byte0, dir_rows[i].err);
                    if (dir_rows[i].n_exp == 2)
                        put_byte(dir_rows[i].byte1, 1'b0);
                    mark_last(int'(dir_rows[i].n_exp));
                end
                idle_gap();
            end
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_quiet();
            setup_phase(p);
            taken = 0;
            tries = 0;
            while (taken < PHASE_BYTES && tries < PHASE_TRIES)
            begin
                a = pick_action();
                b = pick_byte();
                push_req(a, b, n);
                if (byte_taken)
                    taken++;
                tries++;
                if (p == 4 && tries == 50)
                    wait_quiet();
                else
                    idle_gap();
            end
        end

        wait_quiet();
        repeat (20) @(posedge clk);

        $display("summary: %0d requests, %0d bytes checked, %0d register writes,",
                 req_count, checked_count, write_count);
        $display("summary: %0d receiver hold-offs over %0d random phases",
                 hold_count, N_PHASES);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
